>>> src/vvm_pkg.sv
// Shared types, constants and codes of the vibration velocity meter.
package vvm_pkg;

   // Window depth default and fixed datapath widths
   localparam int WINDOW_DEPTH_DEF = 4096;
   localparam int SUM_W            = 48;
   localparam int CFG_W            = 24;

   // Configuration register indexes
   localparam logic [2:0] REG_HIGHPASS_ALPHA   = 3'd0;
   localparam logic [2:0] REG_INTEGRATION_GAIN = 3'd1;
   localparam logic [2:0] REG_ENVELOPE_RATE    = 3'd2;
   localparam logic [2:0] REG_OUTPUT_SCALE     = 3'd3;
   localparam logic [2:0] REG_CLAMP_LIMIT      = 3'd4;
   localparam logic [2:0] REG_CODE_SCALE       = 3'd5;
   localparam logic [2:0] REG_ALARM_THRESHOLD  = 3'd6;
   localparam logic [2:0] REG_CHANNEL_TAG      = 3'd7;

   // Register reset values
   localparam logic [15:0] RST_HIGHPASS_ALPHA   = 16'd4588;
   localparam logic [23:0] RST_INTEGRATION_GAIN = 24'd80282;
   localparam logic [23:0] RST_ENVELOPE_RATE    = 24'd8779;
   localparam logic [23:0] RST_OUTPUT_SCALE     = 24'd908271;
   localparam logic [23:0] RST_CLAMP_LIMIT      = 24'd4390912;
   localparam logic [23:0] RST_CODE_SCALE       = 24'd72818;
   localparam logic [23:0] RST_ALARM_THRESHOLD  = 24'd2949120;
   localparam logic [7:0]  RST_CHANNEL_TAG      = 8'd1;

   typedef struct packed {
      logic [15:0] highpass_alpha;
      logic [23:0] integration_gain;
      logic [23:0] envelope_rate;
      logic [23:0] output_scale;
      logic [23:0] clamp_limit;
      logic [23:0] code_scale;
      logic [23:0] alarm_threshold;
      logic [7:0]  channel_tag;
   } cfg_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MEAN_MUL, S_MEAN_ACC, S_HP, S_VEL_MUL, S_VEL_ACC, S_MAG,
      S_ENV_MUL, S_ENV_ACC, S_WIN, S_VIB_MUL, S_VIB_CLAMP, S_CODE_MUL, S_OUT
   } state_type;

   // Operand select of the shared multiplier
   typedef enum logic [2:0] {
      MUL_MEAN, MUL_VEL, MUL_ENV, MUL_VIB, MUL_CODE
   } mul_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        load_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        mean_acc;
      logic        hp;
      logic        vel_acc;
      logic        mag;
      logic        env_acc;
      logic        win;
      logic        vib_clamp;
      logic        out_load;
      logic        clear_step;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic run;
      logic clear_last;
      logic out_full;
   } sts_type;

endpackage

>>> src/vvm_ctrl.sv
// Sequencer of the vibration velocity meter: steps one sample through the datapath.
module vvm_ctrl
   import vvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // State register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (sts.clear_last) state_in = S_IDLE;
         S_IDLE: begin
            if (sts.req_valid) state_in = sts.run ? S_MEAN_MUL : S_CLEAR;
         end
         S_MEAN_MUL:  state_in = S_MEAN_ACC;
         S_MEAN_ACC:  state_in = S_HP;
         S_HP:        state_in = S_VEL_MUL;
         S_VEL_MUL:   state_in = S_VEL_ACC;
         S_VEL_ACC:   state_in = S_MAG;
         S_MAG:       state_in = S_ENV_MUL;
         S_ENV_MUL:   state_in = S_ENV_ACC;
         S_ENV_ACC:   state_in = S_WIN;
         S_WIN:       state_in = S_VIB_MUL;
         S_VIB_MUL:   state_in = S_VIB_CLAMP;
         S_VIB_CLAMP: state_in = S_CODE_MUL;
         S_CODE_MUL:  state_in = S_OUT;
         S_OUT:       if (!sts.out_full) state_in = S_IDLE;
         default:     state_in = S_CLEAR;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_MEAN;
      unique case (state_ff)
         S_CLEAR: cmd.clear_step = 1'b1;
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.load_in   = sts.req_valid & sts.run;
         end
         S_MEAN_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_MEAN;
         end
         S_MEAN_ACC: cmd.mean_acc = 1'b1;
         S_HP:       cmd.hp = 1'b1;
         S_VEL_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_VEL;
         end
         S_VEL_ACC: cmd.vel_acc = 1'b1;
         S_MAG:     cmd.mag = 1'b1;
         S_ENV_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ENV;
         end
         S_ENV_ACC: cmd.env_acc = 1'b1;
         S_WIN:     cmd.win = 1'b1;
         S_VIB_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_VIB;
         end
         S_VIB_CLAMP: cmd.vib_clamp = 1'b1;
         S_CODE_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CODE;
         end
         S_OUT:   cmd.out_load = !sts.out_full;
         default: cmd = '0;
      endcase
   end

   // Result register is never overwritten while it still holds an untaken result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.out_full)
      else $error("result loaded while output register full");

   // A processed sample enters the multiply chain right after acceptance
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> state_ff == S_MEAN_MUL)
      else $error("accepted sample did not start processing");

   // No sample is taken while the store is being cleared or a sample is in work
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.req_ready |-> !cmd.clear_step && !cmd.mul_en && !cmd.win))
      else $error("ready raised while busy");

endmodule

>>> src/vvm_dpath.sv
// Datapath of the vibration velocity meter: filter state, window store, window mean, result.
module vvm_dpath
   import vvm_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  cfg_type      cfg,
   input  logic [11:0]  in_raw_code,
   input  logic [31:0]  in_filtered_sample,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic [7:0]   rsp_tag,
   output logic [11:0]  rsp_code_echo,
   output logic [15:0]  rsp_vibration_code,
   output logic         rsp_below_alarm,
   output logic         clear_last,
   output logic         out_full
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_DEPTH - 1);

   // Sample and filter state
   logic signed [31:0] x_ff;
   logic [11:0]        raw_ff;
   logic signed [31:0] mean_ff, mean_in;
   logic signed [31:0] hp_ff, hp_in;
   logic signed [31:0] prev_ff;
   logic signed [39:0] vel_ff, vel_in;
   logic [31:0]        mag_ff, mag_in;
   logic [31:0]        env_ff, env_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      clr_ff;
   logic [31:0]        rd_ff;
   logic [23:0]        vib_ff, vib_in;

   // Window mean
   logic [31:0]        quot_ff;

   // Shared multiplier
   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [57:0] prod_in, prod_ff;
   logic signed [41:0] p16;
   logic signed [33:0] p24;

   // Result register
   logic               rsp_valid_ff;
   logic [7:0]         tag_ff;
   logic [11:0]        echo_ff;
   logic [15:0]        code_ff, code_in;
   logic               below_ff;

   // Intermediate sums
   logic signed [42:0] mean_sum, vel_sum;
   logic signed [32:0] hp_diff;
   logic [39:0]        vel_abs;
   logic signed [34:0] env_sum;
   logic [39:0]        vib_raw;
   logic [23:0]        code_raw;

   logic [31:0] store [WINDOW_DEPTH];

   // Operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_MEAN: begin
            mul_a = {x_ff[31], x_ff} - {mean_ff[31], mean_ff};
            mul_b = {9'd0, cfg.highpass_alpha};
         end
         MUL_VEL: begin
            mul_a = {hp_ff[31], hp_ff} + {prev_ff[31], prev_ff};
            mul_b = {1'b0, cfg.integration_gain};
         end
         MUL_ENV: begin
            mul_a = $signed({1'b0, mag_ff}) - $signed({1'b0, env_ff});
            mul_b = {1'b0, cfg.envelope_rate};
         end
         MUL_VIB: begin
            mul_a = {1'b0, quot_ff};
            mul_b = {1'b0, cfg.output_scale};
         end
         MUL_CODE: begin
            mul_a = {9'd0, vib_ff};
            mul_b = {1'b0, cfg.code_scale};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign p16     = prod_ff[57:16];
   assign p24     = prod_ff[57:24];

   // Mean update, saturated to 32-bit signed
   always_comb begin
      mean_sum = {{11{mean_ff[31]}}, mean_ff} + {p16[41], p16};
      if (mean_sum > 43'sd2147483647)       mean_in = 32'sh7FFFFFFF;
      else if (mean_sum < -43'sd2147483648) mean_in = 32'sh80000000;
      else                                  mean_in = mean_sum[31:0];
   end

   // High-pass value, saturated to 32-bit signed
   always_comb begin
      hp_diff = {x_ff[31], x_ff} - {mean_ff[31], mean_ff};
      if (hp_diff[32] != hp_diff[31]) hp_in = hp_diff[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      else                            hp_in = hp_diff[31:0];
   end

   // Velocity update, saturated to 40-bit signed
   always_comb begin
      vel_sum = {{3{vel_ff[39]}}, vel_ff} + {p16[41], p16};
      if (vel_sum > 43'sd549755813887)       vel_in = 40'sh7FFFFFFFFF;
      else if (vel_sum < -43'sd549755813888) vel_in = 40'sh8000000000;
      else                                   vel_in = vel_sum[39:0];
   end

   // Velocity magnitude, saturated to 32 bits
   always_comb begin
      vel_abs = vel_ff[39] ? 40'(-vel_ff) : 40'(vel_ff);
      mag_in  = (|vel_abs[39:32]) ? 32'hFFFFFFFF : vel_abs[31:0];
   end

   // Envelope update, held in 0 .. 2^32-1
   always_comb begin
      env_sum = $signed({3'b000, env_ff}) + {p24[33], p24};
      if (env_sum[34])              env_in = '0;
      else if (|env_sum[33:32])     env_in = 32'hFFFFFFFF;
      else                          env_in = env_sum[31:0];
   end

   // Window sum and write position
   assign sum_in = sum_ff - {16'd0, rd_ff} + {16'd0, env_ff};
   assign pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;

   // Scaled mean clamp and code saturation
   assign vib_raw  = prod_ff[55:16];
   assign vib_in   = (vib_raw > {16'd0, cfg.clamp_limit}) ? cfg.clamp_limit : vib_raw[23:0];
   assign code_raw = prod_ff[47:24];
   assign code_in  = (|code_raw[23:16]) ? 16'hFFFF : code_raw[15:0];

   // Window store: one write port, registered read at the write position
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         store[clr_ff] <= '0;
      end else if (cmd.win) begin
         store[pos_ff] <= env_ff;
      end
      rd_ff <= store[pos_ff];
   end

   // Filter state and window bookkeeping
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_step) begin
         mean_ff <= '0;
         hp_ff   <= '0;
         prev_ff <= '0;
         vel_ff  <= '0;
         mag_ff  <= '0;
         env_ff  <= '0;
         sum_ff  <= '0;
         pos_ff  <= '0;
      end else begin
         if (cmd.mean_acc) mean_ff <= mean_in;
         if (cmd.hp)       hp_ff <= hp_in;
         if (cmd.vel_acc) begin
            vel_ff  <= vel_in;
            prev_ff <= hp_ff;
         end
         if (cmd.mag)      mag_ff <= mag_in;
         if (cmd.env_acc)  env_ff <= env_in;
         if (cmd.win) begin
            sum_ff <= sum_in;
            pos_ff <= pos_in;
         end
      end
   end

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= (clr_ff == LAST_POS) ? '0 : clr_ff + 1'b1;
      end
   end
   assign clear_last = (clr_ff == LAST_POS);

   // Sample capture, product and clamped vibration
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         x_ff   <= in_filtered_sample;
         raw_ff <= in_raw_code;
      end
      if (cmd.mul_en)    prod_ff <= prod_in;
      if (cmd.vib_clamp) vib_ff <= vib_in;
   end

   // Window mean; the divide is a shift, so the depth must be a power of two; the block does not check it
   always_ff @(posedge clock) begin
      if (cmd.win) quot_ff <= 32'(sum_in >> AW);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         tag_ff   <= cfg.channel_tag;
         echo_ff  <= raw_ff;
         code_ff  <= code_in;
         below_ff <= ({16'd0, vib_ff} <= {16'd0, cfg.alarm_threshold});
      end
   end

   assign out_full           = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_tag            = tag_ff;
   assign rsp_code_echo      = echo_ff;
   assign rsp_vibration_code = code_ff;
   assign rsp_below_alarm    = below_ff;

endmodule

>>> src/vibration_velocity_meter.sv
// Top level of the vibration velocity meter: register file, sequencer and datapath.
//
// One channel: a request transaction carries run (req_tuser) and the raw code and
// filtered acceleration sample (req_tdata). With run high the sample passes a
// high-pass, trapezoidal velocity integration, an envelope follower and a moving
// sum over WINDOW_DEPTH envelopes; one response transaction carries tag, raw code
// echo, 16-bit vibration code and below-alarm flag. With run low no response is
// made and all state is cleared.
// Sequence: a processed sample passes the 13 sequencer steps, five of them through the
// one shared multiplier, before its response is loaded, and the next request is taken
// once the sequencer is back in idle. WINDOW_DEPTH must be a power of two, so that the
// window mean is a shift; the block does not check it.
// Clearing: after reset and after each run-low transaction the window store is
// swept, one entry a cycle over all WINDOW_DEPTH entries, with req_tready low.
// The response sits in an output register; a new request is taken while it waits,
// and a finished sample holds in its last step until the receiver takes the
// previous response. Configuration writes via csr_we take effect at once.
module vibration_velocity_meter
   import vvm_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // raw_code[11:0], filtered_sample[43:12], zero pad
   input  logic [0:0]  req_tuser,   // run[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // tag[7:0], code_echo[19:8], vibration_code[35:20],
                                    // below_alarm[36], zero pad
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   logic [7:0]  rsp_tag;
   logic [11:0] rsp_code_echo;
   logic [15:0] rsp_vibration_code;
   logic        rsp_below_alarm;

   // Configuration register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.highpass_alpha   <= RST_HIGHPASS_ALPHA;
         cfg_ff.integration_gain <= RST_INTEGRATION_GAIN;
         cfg_ff.envelope_rate    <= RST_ENVELOPE_RATE;
         cfg_ff.output_scale     <= RST_OUTPUT_SCALE;
         cfg_ff.clamp_limit      <= RST_CLAMP_LIMIT;
         cfg_ff.code_scale       <= RST_CODE_SCALE;
         cfg_ff.alarm_threshold  <= RST_ALARM_THRESHOLD;
         cfg_ff.channel_tag      <= RST_CHANNEL_TAG;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HIGHPASS_ALPHA:   cfg_ff.highpass_alpha   <= csr_wdata[15:0];
            REG_INTEGRATION_GAIN: cfg_ff.integration_gain <= csr_wdata;
            REG_ENVELOPE_RATE:    cfg_ff.envelope_rate    <= csr_wdata;
            REG_OUTPUT_SCALE:     cfg_ff.output_scale     <= csr_wdata;
            REG_CLAMP_LIMIT:      cfg_ff.clamp_limit      <= csr_wdata;
            REG_CODE_SCALE:       cfg_ff.code_scale       <= csr_wdata;
            REG_ALARM_THRESHOLD:  cfg_ff.alarm_threshold  <= csr_wdata;
            REG_CHANNEL_TAG:      cfg_ff.channel_tag      <= csr_wdata[7:0];
            default:              cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign req_tready    = cmd.req_ready;
   assign sts.req_valid = req_tvalid;
   assign sts.run       = req_tuser[0];

   vvm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   vvm_dpath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg_ff),
      .in_raw_code        (req_tdata[11:0]),
      .in_filtered_sample (req_tdata[43:12]),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tag            (rsp_tag),
      .rsp_code_echo      (rsp_code_echo),
      .rsp_vibration_code (rsp_vibration_code),
      .rsp_below_alarm    (rsp_below_alarm),
      .clear_last         (sts.clear_last),
      .out_full           (sts.out_full)
   );

   assign rsp_tdata = {3'd0, rsp_below_alarm, rsp_vibration_code, rsp_code_echo, rsp_tag};

endmodule

>>> bench/tb_vibration_velocity_meter.sv
// Testbench of the vibration velocity meter: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_vibration_velocity_meter
   import vvm_pkg::*;
();

   localparam int DEPTH = WINDOW_DEPTH_DEF;
   localparam int CLEAR_WAIT = DEPTH + 200;

   typedef struct packed {
      logic [7:0]  tag;
      logic [11:0] code_echo;
      logic [15:0] vibration_code;
      logic        below_alarm;
   } meter_result_type;

   typedef struct {
      logic             run;
      logic [11:0]      raw;
      logic [31:0]      sample;
      bit               typed;
      meter_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   vibration_velocity_meter DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the configuration registers
   cfg_type cfg_mirror;
   // Mirror of the channel state
   longint mean_lvl, prev_hp, vel_acc, env_lvl;
   longint unsigned win_sum;
   logic [31:0] win_store [DEPTH];
   int unsigned win_pos;

   meter_result_type pending_results[$];
   int errors = 0;
   bit calm = 0;

   function automatic void clear_channel();
      mean_lvl = 0; prev_hp = 0; vel_acc = 0; env_lvl = 0;
      win_sum = 0; win_pos = 0;
      foreach (win_store[i]) win_store[i] = '0;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Advance the channel by one sample; returns 1 with the result when one is made
   function automatic bit advance_meter(logic run, logic [11:0] raw, logic [31:0] s,
                                        output meter_result_type r);
      longint x, hp, mag;
      longint unsigned mean, vib, code;
      r = '0;
      if (!run) begin
         clear_channel();
         return 0;
      end
      x = longint'($signed(s));
      mean_lvl += ((x - mean_lvl) * longint'(cfg_mirror.highpass_alpha)) >>> 16;
      mean_lvl = clip(mean_lvl, -64'sd2147483648, 64'sd2147483647);
      hp = clip(x - mean_lvl, -64'sd2147483648, 64'sd2147483647);
      vel_acc += ((hp + prev_hp) * longint'(cfg_mirror.integration_gain)) >>> 16;
      vel_acc = clip(vel_acc, -64'sd549755813888, 64'sd549755813887);
      prev_hp = hp;
      mag = vel_acc < 0 ? -vel_acc : vel_acc;
      if (mag > 64'sd4294967295) mag = 64'sd4294967295;
      env_lvl += ((mag - env_lvl) * longint'(cfg_mirror.envelope_rate)) >>> 24;
      env_lvl = clip(env_lvl, 0, 64'sd4294967295);
      // moving window over the envelope
      win_sum = win_sum - win_store[win_pos] + longint'(env_lvl);
      win_store[win_pos] = env_lvl[31:0];
      win_pos = (win_pos + 1) % DEPTH;
      mean = win_sum / DEPTH;
      vib = (mean * cfg_mirror.output_scale) >> 16;
      if (vib > cfg_mirror.clamp_limit) vib = cfg_mirror.clamp_limit;
      code = (vib * cfg_mirror.code_scale) >> 24;
      if (code > 64'hFFFF) code = 64'hFFFF;
      r.tag = cfg_mirror.channel_tag;
      r.code_echo = raw;
      r.vibration_code = code[15:0];
      r.below_alarm = vib <= cfg_mirror.alarm_threshold;
      return 1;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_HIGHPASS_ALPHA:   cfg_mirror.highpass_alpha = val[15:0];
         REG_INTEGRATION_GAIN: cfg_mirror.integration_gain = val;
         REG_ENVELOPE_RATE:    cfg_mirror.envelope_rate = val;
         REG_OUTPUT_SCALE:     cfg_mirror.output_scale = val;
         REG_CLAMP_LIMIT:      cfg_mirror.clamp_limit = val;
         REG_CODE_SCALE:       cfg_mirror.code_scale = val;
         REG_ALARM_THRESHOLD:  cfg_mirror.alarm_threshold = val;
         REG_CHANNEL_TAG:      cfg_mirror.channel_tag = val[7:0];
         default: ;
      endcase
   endtask

   // Wait for the channel to drain, including any store sweep still running
   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (CLEAR_WAIT) @(posedge clock);
   endtask

   // Send one request transaction; typed rows carry their own expectation
   task automatic send_sample(logic run, logic [11:0] raw, logic [31:0] s,
                              bit typed = 0, meter_result_type want = '0);
      meter_result_type r;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 34) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = run;
      req_tdata = {4'b0, s, raw};
      do @(posedge clock); while (!req_tready);
      if (advance_meter(run, raw, s, r))
         pending_results.push_back(typed ? want : r);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Random sample, shaped toward small signals with some extremes
   function automatic logic [31:0] pick_sample();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 * 2 ** 20) - 2 ** 20));
         2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(2 * 2 ** 12) - 2 ** 12));
      endcase
   endfunction

   task automatic random_run(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(199) == 0) begin
            while (pending_results.size() != 0) @(posedge clock);
         end
         send_sample($urandom_range(99) != 0, 12'($urandom), pick_sample());
      end
   endtask

   // Receiver stalls
   always @(negedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= 34);

   // Response checker
   always @(posedge clock) begin
      meter_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tag = rsp_tdata[7:0];
         got.code_echo = rsp_tdata[19:8];
         got.vibration_code = rsp_tdata[35:20];
         got.below_alarm = rsp_tdata[36];
         if (pending_results.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.tag !== want.tag) begin
               $error("tag: expected %0d, got %0d", want.tag, got.tag); errors++;
            end
            if (got.code_echo !== want.code_echo) begin
               $error("code_echo: expected %h, got %h", want.code_echo, got.code_echo);
               errors++;
            end
            if (got.vibration_code !== want.vibration_code) begin
               $error("vibration_code: expected %0d, got %0d",
                      want.vibration_code, got.vibration_code);
               errors++;
            end
            if (got.below_alarm !== want.below_alarm) begin
               $error("below_alarm: expected %0d, got %0d",
                      want.below_alarm, got.below_alarm);
               errors++;
            end
         end
      end
   end

   // Run limit
   initial begin
      #60_000_000;
      $display("tb_vibration_velocity_meter: errors");
      $finish;
   end

   stim_row_type directed[] = '{
      // fresh state: zero sample gives zero code, below alarm
      '{1'b1, 12'h800, 32'h0, 1, '{8'd1, 12'h800, 16'd0, 1'b1}},
      '{1'b1, 12'h7FF, 32'h0, 1, '{8'd1, 12'h7FF, 16'd0, 1'b1}},
      '{1'b1, 12'h000, 32'h7FFFFFFF, 0, '0},
      '{1'b1, 12'hFFF, 32'h80000000, 0, '0},
      '{1'b1, 12'h555, 32'h80000000, 0, '0},
      '{1'b1, 12'hAAA, 32'h7FFFFFFF, 0, '0},
      '{1'b1, 12'h123, 32'h00010000, 0, '0},
      '{1'b1, 12'h321, 32'hFFFF0000, 0, '0},
      // run low clears everything and makes no response
      '{1'b0, 12'hFFF, 32'hFFFFFFFF, 0, '0},
      '{1'b1, 12'h001, 32'h0, 1, '{8'd1, 12'h001, 16'd0, 1'b1}},
      '{1'b1, 12'h0F0, 32'hAAAAAAAA, 0, '0},
      '{1'b1, 12'hF0F, 32'h55555555, 0, '0}
   };

   initial begin
      cfg_mirror = '{RST_HIGHPASS_ALPHA, RST_INTEGRATION_GAIN, RST_ENVELOPE_RATE,
                     RST_OUTPUT_SCALE, RST_CLAMP_LIMIT, RST_CODE_SCALE,
                     RST_ALARM_THRESHOLD, RST_CHANNEL_TAG};
      clear_channel();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_sample(directed[i].run, directed[i].raw, directed[i].sample,
                     directed[i].typed, directed[i].want);
      random_run(450);

      // saturating setting: velocity, envelope and code all pinned, no stalls
      drain();
      write_reg(REG_HIGHPASS_ALPHA, 24'h0);
      write_reg(REG_INTEGRATION_GAIN, 24'hFFFFFF);
      write_reg(REG_ENVELOPE_RATE, 24'hFFFFFF);
      write_reg(REG_OUTPUT_SCALE, 24'hFFFFFF);
      write_reg(REG_CLAMP_LIMIT, 24'hFFFFFF);
      write_reg(REG_CODE_SCALE, 24'hFFFFFF);
      write_reg(REG_ALARM_THRESHOLD, 24'hFFFFFE);
      write_reg(REG_CHANNEL_TAG, 24'hFF);
      calm = 1;
      random_run(350);
      calm = 0;

      // all registers at their floor but the high-pass alpha, which is at its top
      drain();
      write_reg(REG_HIGHPASS_ALPHA, 24'hFFFF);
      write_reg(REG_INTEGRATION_GAIN, 24'h0);
      write_reg(REG_ENVELOPE_RATE, 24'h0);
      write_reg(REG_OUTPUT_SCALE, 24'h0);
      write_reg(REG_CLAMP_LIMIT, 24'h0);
      write_reg(REG_CODE_SCALE, 24'h0);
      write_reg(REG_ALARM_THRESHOLD, 24'h0);
      write_reg(REG_CHANNEL_TAG, 24'h0);
      random_run(250);

      // random settings
      for (int p = 0; p < 5; p++) begin
         drain();
         for (int k = 0; k < 8; k++)
            write_reg(3'(k), 24'($urandom));
         random_run(200);
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("tb_vibration_velocity_meter: clean");
      else
         $display("tb_vibration_velocity_meter: errors");
      $finish;
   end

endmodule
